@@ src/skd_pkg.sv @@
// Shared constants and types for the stochastic KD oscillator core.
package skd_pkg;

    localparam int PRICE_W         = 32;
    localparam int PCT_INT_W       = 7;
    localparam int PCT_SCALE       = 100;
    localparam int PCT_HALF        = 50;
    localparam int WINDOW_BARS_DEF = 9;
    localparam int FRAC_BITS_DEF   = 16;

    typedef struct packed {
        logic [PRICE_W-1:0] hi;
        logic [PRICE_W-1:0] lo;
    } hl_t;

    typedef struct packed {
        logic shift;
        logic clear;
    } cell_ctl_t;

endpackage

@@ src/stochastic_kd_oscillator_core.sv @@
// Stochastic oscillator KD core: bar window, RSV and smoothed K/D lines.
//
// Input channel (in_valid/in_ready): one bar word per handshake, carrying
// bar_high, bar_low, bar_close and series_start. series_start clears the
// window, bar count and both lines to fifty percent before the bar is taken.
// Output channel (out_valid/out_ready): one word per bar with k_value,
// d_value and warmed_up.
// One bar is worked on at a time; in_ready is high between bars, also while
// the previous result still waits in the output register.
// Before the full window the bar goes straight to the output state, and the
// word is loaded from there. After it, the word waits for the systolic
// max/min pass through the cell row, the RSV step, the one-bit-per-cycle
// ratio divider when the ratio is not fixed, and the four-bit-per-cycle /3
// steps for K and then D. The next bar is taken once the word is loaded.
// If the receiver stalls, the finished word holds in the output register;
// the next bar is still taken and its result waits until the register frees.
// Reset clears the window and count, sets K and D to fifty percent and
// drops out_valid.
module stochastic_kd_oscillator_core #(
    parameter int WINDOW_BARS = skd_pkg::WINDOW_BARS_DEF,
    parameter int FRAC_BITS   = skd_pkg::FRAC_BITS_DEF
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    output logic                                    in_ready,
    input  logic [skd_pkg::PRICE_W-1:0]             bar_high,
    input  logic [skd_pkg::PRICE_W-1:0]             bar_low,
    input  logic [skd_pkg::PRICE_W-1:0]             bar_close,
    input  logic                                    series_start,
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output logic [FRAC_BITS+skd_pkg::PCT_INT_W-1:0] k_value,
    output logic [FRAC_BITS+skd_pkg::PCT_INT_W-1:0] d_value,
    output logic                                    warmed_up
);
    import skd_pkg::*;

    localparam int W       = WINDOW_BARS;
    localparam int PCT_W   = FRAC_BITS + PCT_INT_W;
    localparam int SUM_W   = PCT_W + 2;
    localparam int D3_CYC  = (SUM_W + 3) / 4;
    localparam int D3_W    = D3_CYC * 4;
    localparam int CNT_MAX = (W > D3_CYC) ? W : D3_CYC;
    localparam int CNT_W   = $clog2(CNT_MAX);
    localparam int BARS_W  = $clog2(W + 1);

    localparam logic [PCT_W-1:0] FIFTY_FX   = PCT_W'(PCT_HALF) << FRAC_BITS;
    localparam logic [PCT_W-1:0] HUNDRED_FX = PCT_W'(PCT_SCALE) << FRAC_BITS;
    localparam logic [2:0]       THREE      = 3'd3;

    typedef enum logic [3:0] {
        S_IDLE, S_SCAN, S_PREP, S_DIV, S_KSUM, S_KDIV, S_DSUM, S_DDIV, S_OUT
    } state_t;

    state_t              state_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [BARS_W-1:0]   bars_reg;
    logic                warm_reg;
    logic [PRICE_W-1:0]  close_reg;
    logic [PCT_W-1:0]    rsv_reg;
    logic [PCT_W-1:0]    k_line_reg;
    logic [PCT_W-1:0]    d_line_reg;
    logic [D3_W-1:0]     d3_sh_reg;
    logic [1:0]          d3_rem_reg;
    logic                out_valid_reg;
    logic [PCT_W-1:0]    k_value_reg;
    logic [PCT_W-1:0]    d_value_reg;
    logic                warmed_up_reg;

    logic                accept;
    logic [BARS_W-1:0]   bars_next;
    logic                warm_next;
    logic                out_free;

    hl_t                 bar_chain [0:W];
    hl_t                 run_chain [0:W];

    logic [PRICE_W-1:0]  hh;
    logic [PRICE_W-1:0]  ll;
    logic                use_div;
    logic [PCT_W-1:0]    rsv_fix;
    logic [PRICE_W-1:0]  prep_num;
    logic [PRICE_W-1:0]  prep_den;
    logic                div_start;
    logic                div_done;
    logic [PCT_W-1:0]    div_quot;

    logic [D3_W-1:0]     d3_sh_next;
    logic [1:0]          d3_rem_next;
    logic [SUM_W-1:0]    k_sum;
    logic [SUM_W-1:0]    d_sum;

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign bars_next = series_start ? BARS_W'(1)
                     : (bars_reg == BARS_W'(W)) ? bars_reg : bars_reg + 1'b1;
    assign warm_next = (bars_next == BARS_W'(W));

    // Cell row: bars shift in at cell 0, running extremes sweep to the far end.
    assign bar_chain[0] = '{hi: bar_high, lo: bar_low};
    assign run_chain[0] = '{hi: '0, lo: '1};

    for (genvar i = 0; i < W; i++)
    begin : g_cell
        cell_ctl_t ctl;
        assign ctl.shift = accept;
        assign ctl.clear = series_start && (i != 0);
        skd_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctl     (ctl),
            .bar_in  (bar_chain[i]),
            .run_in  (run_chain[i]),
            .bar_out (bar_chain[i+1]),
            .run_out (run_chain[i+1])
        );
    end

    assign hh = run_chain[W].hi;
    assign ll = run_chain[W].lo;

    always_comb
    begin
        use_div  = 1'b0;
        rsv_fix  = FIFTY_FX;
        prep_num = close_reg - ll;
        prep_den = hh - ll;
        if (hh == ll)
        begin
            rsv_fix = FIFTY_FX;
        end
        else if (hh > ll)
        begin
            if (close_reg <= ll)
            begin
                rsv_fix = '0;
            end
            else if (close_reg >= hh)
            begin
                rsv_fix = HUNDRED_FX;
            end
            else
            begin
                use_div = 1'b1;
            end
        end
        else
        begin
            // inverted window: same quotient with both signs flipped
            prep_num = ll - close_reg;
            prep_den = ll - hh;
            if (close_reg >= ll)
            begin
                rsv_fix = '0;
            end
            else if (close_reg <= hh)
            begin
                rsv_fix = HUNDRED_FX;
            end
            else
            begin
                use_div = 1'b1;
            end
        end
    end

    assign div_start = (state_reg == S_PREP) && use_div;

    skd_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (prep_num),
        .den   (prep_den),
        .done  (div_done),
        .quot  (div_quot)
    );

    // Divide by three, four quotient bits per cycle; quotient shifts in below.
    always_comb
    begin
        logic [1:0]      rem;
        logic [D3_W-1:0] sh;
        logic [2:0]      t;
        logic            qb;
        rem = d3_rem_reg;
        sh  = d3_sh_reg;
        for (int j = 0; j < 4; j++)
        begin
            t   = {rem, sh[D3_W-1]};
            qb  = (t >= THREE);
            rem = qb ? 2'(t - THREE) : t[1:0];
            sh  = {sh[D3_W-2:0], qb};
        end
        d3_rem_next = rem;
        d3_sh_next  = sh;
    end

    assign k_sum = SUM_W'({k_line_reg, 1'b0}) + SUM_W'(rsv_reg);
    assign d_sum = SUM_W'({d_line_reg, 1'b0}) + SUM_W'(k_line_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            bars_reg      <= '0;
            warm_reg      <= 1'b0;
            close_reg     <= '0;
            rsv_reg       <= '0;
            k_line_reg    <= FIFTY_FX;
            d_line_reg    <= FIFTY_FX;
            d3_sh_reg     <= '0;
            d3_rem_reg    <= '0;
            out_valid_reg <= 1'b0;
            k_value_reg   <= '0;
            d_value_reg   <= '0;
            warmed_up_reg <= 1'b0;
        end
        else
        begin
            // drop the word once taken, unless a new one is loaded now
            if (out_valid_reg && out_ready && (state_reg != S_OUT))
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        bars_reg  <= bars_next;
                        warm_reg  <= warm_next;
                        close_reg <= bar_close;
                        cnt_reg   <= '0;
                        if (series_start)
                        begin
                            k_line_reg <= FIFTY_FX;
                            d_line_reg <= FIFTY_FX;
                        end
                        state_reg <= warm_next ? S_SCAN : S_OUT;
                    end
                end
                S_SCAN:
                begin
                    // wait for the sweep to reach the last cell
                    if (cnt_reg == CNT_W'(W - 1))
                    begin
                        cnt_reg   <= '0;
                        state_reg <= S_PREP;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                S_PREP:
                begin
                    if (use_div)
                    begin
                        state_reg <= S_DIV;
                    end
                    else
                    begin
                        rsv_reg   <= rsv_fix;
                        state_reg <= S_KSUM;
                    end
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        rsv_reg   <= div_quot;
                        state_reg <= S_KSUM;
                    end
                end
                S_KSUM:
                begin
                    d3_sh_reg  <= D3_W'(k_sum);
                    d3_rem_reg <= '0;
                    cnt_reg    <= '0;
                    state_reg  <= S_KDIV;
                end
                S_KDIV:
                begin
                    d3_sh_reg  <= d3_sh_next;
                    d3_rem_reg <= d3_rem_next;
                    if (cnt_reg == CNT_W'(D3_CYC - 1))
                    begin
                        k_line_reg <= d3_sh_next[PCT_W-1:0];
                        cnt_reg    <= '0;
                        state_reg  <= S_DSUM;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                S_DSUM:
                begin
                    d3_sh_reg  <= D3_W'(d_sum);
                    d3_rem_reg <= '0;
                    cnt_reg    <= '0;
                    state_reg  <= S_DDIV;
                end
                S_DDIV:
                begin
                    d3_sh_reg  <= d3_sh_next;
                    d3_rem_reg <= d3_rem_next;
                    if (cnt_reg == CNT_W'(D3_CYC - 1))
                    begin
                        d_line_reg <= d3_sh_next[PCT_W-1:0];
                        cnt_reg    <= '0;
                        state_reg  <= S_OUT;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                S_OUT:
                begin
                    // hold until the output register is free
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        k_value_reg   <= k_line_reg;
                        d_value_reg   <= d_line_reg;
                        warmed_up_reg <= warm_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign k_value   = k_value_reg;
    assign d_value   = d_value_reg;
    assign warmed_up = warmed_up_reg;

    a_warmup_fifty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !warmed_up |-> (k_value == FIFTY_FX) && (d_value == FIFTY_FX))
        else $error("K or D left fifty percent during warm-up");

    a_line_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (k_value <= HUNDRED_FX) && (d_value <= HUNDRED_FX))
        else $error("K or D above one hundred percent");

    a_div_owner: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == S_DIV)
        else $error("divider finished outside its wait state");

    a_prep_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_PREP |-> $past(state_reg == S_SCAN))
        else $error("RSV prepared without a full window sweep");

    a_bars_bound: assert property (@(posedge clk) disable iff (!rst_n)
        bars_reg <= BARS_W'(W))
        else $error("bar count beyond window length");

endmodule

@@ src/skd_cell.sv @@
// One window cell: holds one bar's high and low and a running max/min stage.
module skd_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  skd_pkg::cell_ctl_t ctl,
    input  skd_pkg::hl_t      bar_in,
    input  skd_pkg::hl_t      run_in,
    output skd_pkg::hl_t      bar_out,
    output skd_pkg::hl_t      run_out
);
    import skd_pkg::*;

    hl_t bar_reg;
    hl_t run_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bar_reg <= '0;
        end
        else if (ctl.shift)
        begin
            bar_reg <= ctl.clear ? '0 : bar_in;
        end
    end

    // Fold this cell's bar into the running extremes from the upstream cell.
    always_ff @(posedge clk)
    begin
        run_reg.hi <= (run_in.hi > bar_reg.hi) ? run_in.hi : bar_reg.hi;
        run_reg.lo <= (run_in.lo < bar_reg.lo) ? run_in.lo : bar_reg.lo;
    end

    assign bar_out = bar_reg;
    assign run_out = run_reg;

endmodule

@@ src/skd_div.sv @@
// Bit-serial divider for the scaled ratio 100 * num * 2^FRAC_BITS / den.
module skd_div #(
    parameter int FRAC_BITS = skd_pkg::FRAC_BITS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    input  logic [skd_pkg::PRICE_W-1:0]            num,
    input  logic [skd_pkg::PRICE_W-1:0]            den,
    output logic                                   done,
    output logic [FRAC_BITS+skd_pkg::PCT_INT_W-1:0] quot
);
    import skd_pkg::*;

    localparam int PCT_W  = FRAC_BITS + PCT_INT_W;
    localparam int MUL_W  = PRICE_W + PCT_INT_W;
    localparam int STEP_W = $clog2(PCT_W);

    typedef enum logic [1:0] {D_IDLE, D_LOAD, D_RUN} dstate_t;

    dstate_t             dstate_reg;
    logic [STEP_W-1:0]   step_reg;
    logic                done_reg;
    logic [PRICE_W-1:0]  num_reg;
    logic [PRICE_W-1:0]  den_reg;
    logic [PRICE_W-1:0]  rem_reg;
    logic [PCT_W-1:0]    feed_reg;
    logic [PCT_W-1:0]    q_reg;

    logic [MUL_W-1:0]    prod;
    logic [PRICE_W:0]    trial;
    logic [PRICE_W:0]    diff;
    logic                ge;
    logic [PRICE_W-1:0]  rem_next;

    // num < den, so the top PRICE_W bits of the dividend are already below den.
    assign prod     = {{PCT_INT_W{1'b0}}, num_reg} * MUL_W'(PCT_SCALE);
    assign trial    = {rem_reg, feed_reg[PCT_W-1]};
    assign diff     = trial - {1'b0, den_reg};
    assign ge       = trial >= {1'b0, den_reg};
    assign rem_next = ge ? diff[PRICE_W-1:0] : trial[PRICE_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dstate_reg <= D_IDLE;
            step_reg   <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (dstate_reg)
                D_IDLE:
                begin
                    if (start)
                    begin
                        dstate_reg <= D_LOAD;
                    end
                end
                D_LOAD:
                begin
                    step_reg   <= '0;
                    dstate_reg <= D_RUN;
                end
                D_RUN:
                begin
                    if (step_reg == STEP_W'(PCT_W - 1))
                    begin
                        done_reg   <= 1'b1;
                        dstate_reg <= D_IDLE;
                    end
                    else
                    begin
                        step_reg <= step_reg + 1'b1;
                    end
                end
                default:
                begin
                    dstate_reg <= D_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (dstate_reg)
            D_IDLE:
            begin
                if (start)
                begin
                    num_reg <= num;
                    den_reg <= den;
                end
            end
            D_LOAD:
            begin
                rem_reg  <= prod[MUL_W-1 -: PRICE_W];
                feed_reg <= {prod[PCT_INT_W-1:0], {FRAC_BITS{1'b0}}};
                q_reg    <= '0;
            end
            D_RUN:
            begin
                rem_reg  <= rem_next;
                feed_reg <= {feed_reg[PCT_W-2:0], 1'b0};
                q_reg    <= {q_reg[PCT_W-2:0], ge};
            end
            default:
            begin
                rem_reg <= rem_reg;
            end
        endcase
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule
